/* sv/digit_blink_echo_sequencer_macros.svh */
// ---------------------------------------------------------------------------
// Digit blink echo sequencer assertion macros
// Concurrent checks sampled on clk and switched off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef DIGIT_BLINK_ECHO_SEQUENCER_MACROS_SVH
`define DIGIT_BLINK_ECHO_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define DBES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DBES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DBES_ASSERT_SAME(lbl, ante, cons, msg)
`define DBES_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/dbes_pkg.sv */
// ---------------------------------------------------------------------------
// Digit blink echo sequencer package
// Transaction types, register map and reset values shared by the block.
// ---------------------------------------------------------------------------
package dbes_pkg;

	localparam int QUEUE_SLOTS_DEF = 16;

	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 2;
	localparam int TICK_W   = 16;
	localparam int COUNT_W  = 4;
	localparam int DIGIT_W  = 4;

	localparam logic [REG_IDX_W-1:0] REG_PREGAP = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ON     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFF    = 2'd2;

	localparam logic [TICK_W-1:0] PREGAP_RST = 16'd250;
	localparam logic [TICK_W-1:0] ON_RST     = 16'd150;
	localparam logic [TICK_W-1:0] OFF_RST    = 16'd150;

	localparam logic [COUNT_W-1:0] ZERO_DIGIT_COUNT = 4'd10;

	typedef struct packed {
		logic               action;
		logic [DIGIT_W-1:0] digit;
		logic               rest_level;
	} in_t;

	typedef struct packed {
		logic lamp;
		logic dropped;
	} out_t;

	typedef struct packed {
		logic [TICK_W-1:0] pregap_ticks;
		logic [TICK_W-1:0] on_ticks;
		logic [TICK_W-1:0] off_ticks;
	} cfg_t;

	typedef struct packed {
		logic out_full;
		logic skid_full;
	} buf_status_t;

endpackage

/* sv/digit_blink_echo_sequencer.sv */
// ---------------------------------------------------------------------------
// Digit blink echo sequencer
// Queues pushed digits and plays each one out as lamp blinks on tick
// transactions.
// ---------------------------------------------------------------------------
// Input channel (in_valid, in_stall, in_data): each transaction is a push
// (action = 1, queues digit) or a one millisecond tick (action = 0).
// Output channel (out_valid, out_stall, out_data): exactly one transaction
// per input transaction, in order, carrying the lamp level after it and
// the dropped flag of a push into a full queue.
// Each accepted transaction's result is registered in the output buffer.
// Throughput: one transaction per cycle while in_stall is low; queue write,
// countdown and phase step are combinational between the state and result registers.
// A stalled receiver fills the result register and then the skid stage;
// in_stall rises only while the skid stage holds a result.
// Reset clears the queue pointers, sequencer and output stages and loads
// the timing registers with 250, 150 and 150 ticks; no clearing pass.
// APB port: pregap at 0x0, on time at 0x4, off time at 0x8, 16 bits each.
// Write registers only while no transaction is in flight.
// ---------------------------------------------------------------------------
`include "digit_blink_echo_sequencer_macros.svh"

module digit_blink_echo_sequencer #(
	parameter int QUEUE_SLOTS = dbes_pkg::QUEUE_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dbes_pkg::PADDR_W-1:0] paddr,
	input  logic [dbes_pkg::PDATA_W-1:0] pwdata,
	output logic [dbes_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  dbes_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output dbes_pkg::out_t               out_data
);

	dbes_pkg::cfg_t                  cfg_q;
	dbes_pkg::out_t                  res;
	dbes_pkg::buf_status_t           buf_status;
	logic                            in_accept;
	logic                            cfg_wr;
	logic [dbes_pkg::REG_IDX_W-1:0]  reg_idx;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[dbes_pkg::PADDR_W-1:2];
	assign in_stall  = buf_status.skid_full;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pregap_ticks <= dbes_pkg::PREGAP_RST;
			cfg_q.on_ticks     <= dbes_pkg::ON_RST;
			cfg_q.off_ticks    <= dbes_pkg::OFF_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				dbes_pkg::REG_PREGAP: cfg_q.pregap_ticks <= pwdata[dbes_pkg::TICK_W-1:0];
				dbes_pkg::REG_ON:     cfg_q.on_ticks     <= pwdata[dbes_pkg::TICK_W-1:0];
				dbes_pkg::REG_OFF:    cfg_q.off_ticks    <= pwdata[dbes_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dbes_pkg::REG_PREGAP: prdata = dbes_pkg::PDATA_W'(cfg_q.pregap_ticks);
			dbes_pkg::REG_ON:     prdata = dbes_pkg::PDATA_W'(cfg_q.on_ticks);
			dbes_pkg::REG_OFF:    prdata = dbes_pkg::PDATA_W'(cfg_q.off_ticks);
			default:              prdata = '0;
		endcase
	end

	dbes_core #(
		.QUEUE_SLOTS(QUEUE_SLOTS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(in_accept),
		.item  (in_data),
		.cfg   (cfg_q),
		.res   (res)
	);

	dbes_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_accept),
		.push_data(res),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.status   (buf_status)
	);

	`DBES_ASSERT_SAME(a_skid_behind_out, buf_status.skid_full, buf_status.out_full, "skid full with empty result register")
	`DBES_ASSERT_SAME(a_drop_only_on_push, in_accept && !in_data.action, !res.dropped, "tick reported a dropped digit")
	`DBES_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid, "accepted transaction left no result")
	`DBES_ASSERT_SAME(a_no_stall_when_empty, !buf_status.out_full, !in_stall, "input stalled with empty output stage")

endmodule

/* sv/dbes_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dbes_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* sv/dbes_core.sv */
// ---------------------------------------------------------------------------
// Digit blink echo sequencer core
// Count queue and tick-driven blink sequencer; one transaction per cycle while accept is high.
// ---------------------------------------------------------------------------
module dbes_core #(
	parameter int QUEUE_SLOTS = dbes_pkg::QUEUE_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  dbes_pkg::in_t  item,
	input  dbes_pkg::cfg_t cfg,
	output dbes_pkg::out_t res
);

	localparam int SLOT_W = $clog2(QUEUE_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREGAP,
		PH_LIT,
		PH_GAP,
		PH_DONE
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic [SLOT_W-1:0]               read_q, read_d;
	logic [SLOT_W-1:0]               write_q, write_d;
	logic [dbes_pkg::COUNT_W-1:0]    blinks_q, blinks_d, blinks_cur;
	logic [dbes_pkg::TICK_W-1:0]     wait_q, wait_d, wait_dec;
	logic                            lamp_q, lamp_d;
	logic                            load_q, load_d;
	logic                            dropped;
	logic                            wr_en;
	logic [dbes_pkg::COUNT_W-1:0]    wr_count;
	logic [dbes_pkg::COUNT_W-1:0]    rd_count;
	logic [SLOT_W-1:0]               write_nxt, read_nxt;

	dbes_ram #(
		.WIDTH(dbes_pkg::COUNT_W),
		.DEPTH(QUEUE_SLOTS)
	) u_queue (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(write_q),
		.wr_data(wr_count),
		.rd_addr(read_q),
		.rd_data(rd_count)
	);

	assign write_nxt  = (write_q == LAST_SLOT) ? '0 : write_q + 1'b1;
	assign read_nxt   = (read_q == LAST_SLOT) ? '0 : read_q + 1'b1;
	assign wr_count   = (item.digit == '0) ? dbes_pkg::ZERO_DIGIT_COUNT : item.digit;
	assign blinks_cur = load_q ? rd_count : blinks_q;
	assign wait_dec   = (wait_q == '0) ? '0 : wait_q - 1'b1;

	always_comb begin
		phase_d  = phase_q;
		read_d   = read_q;
		write_d  = write_q;
		blinks_d = blinks_cur;
		wait_d   = wait_q;
		lamp_d   = lamp_q;
		load_d   = 1'b0;
		dropped  = 1'b0;
		wr_en    = 1'b0;
		if (item.action) begin
			if (write_nxt == read_q) begin
				dropped = 1'b1;
			end else begin
				wr_en   = accept;
				write_d = write_nxt;
			end
		end else if (phase_q == PH_IDLE) begin
			if (read_q != write_q) begin
				read_d  = read_nxt;
				phase_d = PH_PREGAP;
				wait_d  = cfg.pregap_ticks;
				load_d  = 1'b1;
			end
		end else if (wait_dec != '0) begin
			wait_d = wait_dec;
		end else begin
			unique case (phase_q) inside
				PH_PREGAP, PH_GAP: begin
					lamp_d  = 1'b1;
					phase_d = PH_LIT;
					wait_d  = cfg.on_ticks;
				end
				PH_LIT: begin
					lamp_d   = 1'b0;
					blinks_d = blinks_cur - 1'b1;
					wait_d   = cfg.off_ticks;
					phase_d  = (blinks_cur - 1'b1 != '0) ? PH_GAP : PH_DONE;
				end
				default: begin
					lamp_d  = item.rest_level;
					phase_d = PH_IDLE;
					wait_d  = '0;
				end
			endcase
		end
	end

	assign res.lamp    = lamp_d;
	assign res.dropped = dropped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			read_q   <= '0;
			write_q  <= '0;
			blinks_q <= '0;
			wait_q   <= '0;
			lamp_q   <= 1'b0;
			load_q   <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			read_q   <= read_d;
			write_q  <= write_d;
			blinks_q <= blinks_d;
			wait_q   <= wait_d;
			lamp_q   <= lamp_d;
			load_q   <= load_d;
		end else begin
			blinks_q <= blinks_cur;
			load_q   <= 1'b0;
		end
	end

endmodule

/* sv/dbes_outbuf.sv */
// ---------------------------------------------------------------------------
// Digit blink echo sequencer output buffer
// Result register with a skid stage so input waits on a stall only once the skid stage is full.
// ---------------------------------------------------------------------------
module dbes_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dbes_pkg::out_t        push_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output dbes_pkg::out_t        out_data,
	output dbes_pkg::buf_status_t status
);

	logic           out_v_q, skid_v_q;
	dbes_pkg::out_t out_q, skid_q;
	logic           pop;
	logic           load_out, load_from_skid, load_skid;

	assign pop            = out_v_q && !out_stall;
	assign load_from_skid = pop && skid_v_q;
	assign load_out       = push && (!out_v_q || (pop && !skid_v_q));
	assign load_skid      = push && out_v_q && !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_from_skid) begin
				skid_v_q <= 1'b0;
			end else if (load_skid) begin
				skid_v_q <= 1'b1;
			end
			if (!out_v_q || pop) begin
				out_v_q <= load_out || load_from_skid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= push_data;
		end
		if (load_skid) begin
			skid_q <= push_data;
		end
	end

	assign out_valid        = out_v_q;
	assign out_data         = out_q;
	assign status.out_full  = out_v_q;
	assign status.skid_full = skid_v_q;

endmodule
